>>> design/hvi_pkg.sv
package hvi_pkg;

   // default sizes
   localparam int MAX_POINTS_DEF     = 64;
   localparam int MAX_OBJECTIVES_DEF = 4;
   localparam int COORD_BITS_DEF     = 16;

   // fixed port and result widths
   localparam int IN_COORD_BITS = 16;
   localparam int VOL_BITS      = 48;
   localparam int HALF_BITS     = VOL_BITS / 2;
   localparam int CFG_BITS      = 3;

   // objective count after reset
   localparam logic [CFG_BITS-1:0] NOBJ_RESET = 3'd2;

   // order table control from the sequencer
   typedef struct packed {
      logic we;
      logic clr;
   } ord_ctl_type;

endpackage

>>> design/hvi_order.sv
module hvi_order #(
   parameter  int MAX_POINTS = hvi_pkg::MAX_POINTS_DEF,
   localparam int IW         = $clog2(MAX_POINTS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hvi_pkg::ord_ctl_type ctl,
   input  logic [IW-1:0]        wr_addr,
   input  logic [IW-1:0]        wr_data,
   input  logic [IW-1:0]        rd_addr_a,
   input  logic [IW-1:0]        rd_addr_b,
   output logic [IW-1:0]        rd_data_a,
   output logic [IW-1:0]        rd_data_b
);
   import hvi_pkg::*;

   logic [IW-1:0]         order_mem [MAX_POINTS];
   logic [MAX_POINTS-1:0] valid_ff;
   logic [IW-1:0]         data_a_ff, data_b_ff;
   logic [IW-1:0]         addr_a_ff, addr_b_ff;
   logic                  hit_a_ff, hit_b_ff;

   // slot memory, two registered reads
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         order_mem[wr_addr] <= wr_data;
      end
      data_a_ff <= order_mem[rd_addr_a];
      data_b_ff <= order_mem[rd_addr_b];
      addr_a_ff <= rd_addr_a;
      addr_b_ff <= rd_addr_b;
      hit_a_ff  <= valid_ff[rd_addr_a];
      hit_b_ff  <= valid_ff[rd_addr_b];
   end

   // written marks, cleared at once for identity order
   always_ff @(posedge clock) begin
      if (reset || ctl.clr) begin
         valid_ff <= '0;
      end else if (ctl.we) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // unwritten slot holds its own index
   assign rd_data_a = hit_a_ff ? data_a_ff : addr_a_ff;
   assign rd_data_b = hit_b_ff ? data_b_ff : addr_b_ff;

endmodule

>>> design/hvi_store.sv
module hvi_store #(
   parameter  int MAX_POINTS     = hvi_pkg::MAX_POINTS_DEF,
   parameter  int MAX_OBJECTIVES = hvi_pkg::MAX_OBJECTIVES_DEF,
   parameter  int COORD_BITS     = hvi_pkg::COORD_BITS_DEF,
   localparam int AW             = $clog2(MAX_POINTS) + $clog2(MAX_OBJECTIVES)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [COORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]         rd_addr_a,
   input  logic [AW-1:0]         rd_addr_b,
   output logic [COORD_BITS-1:0] rd_data_a,
   output logic [COORD_BITS-1:0] rd_data_b
);
   import hvi_pkg::*;

   localparam int DEPTH = 1 << AW;

   logic [COORD_BITS-1:0] coord_mem [DEPTH];

   // coordinate memory, one write, two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         coord_mem[wr_addr] <= wr_data;
      end
      rd_data_a <= coord_mem[rd_addr_a];
      rd_data_b <= coord_mem[rd_addr_b];
   end

endmodule

>>> design/hvi_mac.sv
module hvi_mac #(
   parameter  int COORD_BITS = hvi_pkg::COORD_BITS_DEF,
   localparam int PW         = hvi_pkg::HALF_BITS + COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [hvi_pkg::VOL_BITS-1:0] acc,
   input  logic [hvi_pkg::VOL_BITS-1:0] vol,
   input  logic [COORD_BITS-1:0]        depth,
   output logic                         done,
   output logic [hvi_pkg::VOL_BITS-1:0] sum
);
   import hvi_pkg::*;

   localparam int WW = PW + HALF_BITS;

   typedef enum logic [1:0] {
      M_IDLE,
      M_LOW,
      M_HIGH
   } mac_state_type;

   mac_state_type        state_ff;
   logic                 done_ff;
   logic [VOL_BITS-1:0]  sum_ff;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [HALF_BITS-1:0] part_ff;
   logic [HALF_BITS-1:0] mul_a;
   logic [WW-1:0]        hi_wide;

   // one shared multiplier, low half first
   assign mul_a   = (state_ff == M_IDLE) ? vol[HALF_BITS-1:0] : vol[VOL_BITS-1:HALF_BITS];
   assign prod_in = {{COORD_BITS{1'b0}}, mul_a} * {{HALF_BITS{1'b0}}, depth};
   assign hi_wide = WW'(prod_ff) << (HALF_BITS - COORD_BITS);

   // sequence and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            M_IDLE: begin
               if (start) begin
                  state_ff <= M_LOW;
               end
            end
            M_LOW: begin
               state_ff <= M_HIGH;
            end
            M_HIGH: begin
               sum_ff   <= acc + VOL_BITS'(part_ff) + VOL_BITS'(hi_wide);
               done_ff  <= 1'b1;
               state_ff <= M_IDLE;
            end
            default: begin
               state_ff <= M_IDLE;
            end
         endcase
      end
   end

   // partial products
   always_ff @(posedge clock) begin
      if (state_ff == M_LOW) begin
         part_ff <= HALF_BITS'(prod_ff >> COORD_BITS);
      end
      if (state_ff != M_HIGH) begin
         prod_ff <= prod_in;
      end
   end

   assign done = done_ff;
   assign sum  = sum_ff;

endmodule

>>> design/hvi_seq.sv
module hvi_seq #(
   parameter  int MAX_POINTS     = hvi_pkg::MAX_POINTS_DEF,
   parameter  int MAX_OBJECTIVES = hvi_pkg::MAX_OBJECTIVES_DEF,
   parameter  int COORD_BITS     = hvi_pkg::COORD_BITS_DEF,
   localparam int IW             = $clog2(MAX_POINTS),
   localparam int OW             = $clog2(MAX_OBJECTIVES),
   localparam int AW             = IW + OW
) (
   input  logic                          clock,
   input  logic                          reset,
   // item channel
   input  logic                          start,
   input  logic [COORD_BITS-1:0]         coord_value,
   input  logic                          last_point,
   output logic                          busy,
   // register write
   input  logic                          csr_valid,
   input  logic [hvi_pkg::CFG_BITS-1:0]  csr_data,
   output logic                          csr_ready,
   // result
   output logic                          rsp_strobe,
   output logic [hvi_pkg::VOL_BITS-1:0]  rsp_volume,
   output logic                          rsp_dropped,
   // coordinate memory
   output logic                          st_we,
   output logic [AW-1:0]                 st_waddr,
   output logic [COORD_BITS-1:0]         st_wdata,
   output logic [AW-1:0]                 st_raddr_a,
   output logic [AW-1:0]                 st_raddr_b,
   input  logic [COORD_BITS-1:0]         st_rdata_a,
   input  logic [COORD_BITS-1:0]         st_rdata_b,
   // order table
   output hvi_pkg::ord_ctl_type          ord_ctl,
   output logic [IW-1:0]                 ord_waddr,
   output logic [IW-1:0]                 ord_wdata,
   output logic [IW-1:0]                 ord_raddr_a,
   output logic [IW-1:0]                 ord_raddr_b,
   input  logic [IW-1:0]                 ord_rdata_a,
   input  logic [IW-1:0]                 ord_rdata_b,
   // multiply unit
   output logic                          mac_start,
   output logic [hvi_pkg::VOL_BITS-1:0]  mac_acc,
   output logic [hvi_pkg::VOL_BITS-1:0]  mac_vol,
   output logic [COORD_BITS-1:0]         mac_depth,
   input  logic                          mac_done,
   input  logic [hvi_pkg::VOL_BITS-1:0]  mac_sum
);
   import hvi_pkg::*;

   localparam int CW         = $clog2(MAX_POINTS + 1);
   localparam int KW         = $clog2(MAX_OBJECTIVES + 1);
   localparam int BASE_LEVEL = 3;

   typedef enum logic [4:0] {
      S_IDLE,
      S_TEST,
      S_F_OUTER,
      S_F_INNER,
      S_F_ORD,
      S_F_RD,
      S_F_CMP,
      S_F_DEC,
      S_SW_W1,
      S_SW_W2,
      S_BASE_O,
      S_BASE_S,
      S_AFTER,
      S_MIN_O,
      S_MIN_S,
      S_MAC,
      S_MAC_W,
      S_RM_O,
      S_RM_S,
      S_RM_NEXT
   } seq_state_type;

   seq_state_type         state_ff, state_in, ret_ff, ret_in;
   logic [CFG_BITS-1:0]   cfg_ff, cfg_in;
   logic [CW-1:0]         loaded_ff, loaded_in;
   logic [OW-1:0]         cidx_ff, cidx_in;
   logic                  ovf_ff, ovf_in;
   logic [KW-1:0]         k_ff, k_in;
   logic                  strobe_ff, strobe_in;
   logic [VOL_BITS-1:0]   volout_ff, volout_in;
   logic                  drop_ff, drop_in;

   logic [CW-1:0]         n_ff, n_in, i_ff, i_in, j_ff, j_in, cnt_ff, cnt_in;
   logic [IW-1:0]         pa_ff, pa_in, pb_ff, pb_in;
   logic [IW-1:0]         sa_ff, sa_in, sb_ff, sb_in, sva_ff, sva_in;
   logic [OW-1:0]         obj_ff, obj_in;
   logic                  age_ff, age_in, agt_ff, agt_in, bge_ff, bge_in, bgt_ff, bgt_in;
   logic [COORD_BITS-1:0] low_ff, low_in;
   logic [VOL_BITS-1:0]   inner_ff, inner_in;

   // per-level slicing stack
   logic [CW-1:0]         cnt_stk_ff  [MAX_OBJECTIVES];
   logic [COORD_BITS-1:0] dist_stk_ff [MAX_OBJECTIVES];
   logic [VOL_BITS-1:0]   vol_stk_ff  [MAX_OBJECTIVES];
   logic [OW-1:0]         stk_idx;
   logic                  stk_we_cnt, stk_we_dist, stk_we_vol;
   logic [CW-1:0]         stk_cnt_wd;
   logic [COORD_BITS-1:0] stk_dist_wd;
   logic [VOL_BITS-1:0]   stk_vol_wd;

   logic [KW-1:0]         nobj;
   logic [OW-1:0]         lv;
   logic [CW-1:0]         stk_cnt;
   logic [VOL_BITS-1:0]   stk_vol;
   logic [CW-1:0]         n_dec, cnt_dec, i_inc;
   logic                  full;
   logic [IW-1:0]         st_ra_pt, st_rb_pt;
   logic [OW-1:0]         st_ra_obj, st_rb_obj;

   // clamp objective count to the supported range
   always_comb begin
      if (32'(cfg_ff) > MAX_OBJECTIVES) begin
         nobj = KW'(MAX_OBJECTIVES);
      end else if (32'(cfg_ff) < 2) begin
         nobj = KW'(2);
      end else begin
         nobj = KW'(cfg_ff);
      end
   end

   assign lv      = OW'(k_ff - 1'b1);
   assign stk_cnt = cnt_stk_ff[lv];
   assign stk_vol = vol_stk_ff[lv];
   assign n_dec   = n_ff - 1'b1;
   assign cnt_dec = cnt_ff - 1'b1;
   assign i_inc   = i_ff + 1'b1;
   assign full    = (loaded_ff == CW'(MAX_POINTS));

   // memory addresses
   assign st_raddr_a = {st_ra_pt, st_ra_obj};
   assign st_raddr_b = {st_rb_pt, st_rb_obj};
   assign st_waddr   = {loaded_ff[IW-1:0], cidx_ff};
   assign st_wdata   = coord_value;

   // multiply operands: inner volume times slice depth, added to the level sum
   assign mac_acc   = stk_vol;
   assign mac_vol   = inner_ff;
   assign mac_depth = low_ff - dist_stk_ff[lv];

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cfg_in    = cfg_ff;
      loaded_in = loaded_ff;
      cidx_in   = cidx_ff;
      ovf_in    = ovf_ff;
      k_in      = k_ff;
      strobe_in = 1'b0;
      volout_in = volout_ff;
      drop_in   = drop_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      cnt_in    = cnt_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      sa_in     = sa_ff;
      sb_in     = sb_ff;
      sva_in    = sva_ff;
      obj_in    = obj_ff;
      age_in    = age_ff;
      agt_in    = agt_ff;
      bge_in    = bge_ff;
      bgt_in    = bgt_ff;
      low_in    = low_ff;
      inner_in  = inner_ff;

      stk_idx     = lv;
      stk_we_cnt  = 1'b0;
      stk_we_dist = 1'b0;
      stk_we_vol  = 1'b0;
      stk_cnt_wd  = '0;
      stk_dist_wd = '0;
      stk_vol_wd  = '0;

      ord_ctl     = '0;
      ord_waddr   = sa_ff;
      ord_wdata   = ord_rdata_b;
      ord_raddr_a = '0;
      ord_raddr_b = '0;
      st_we       = 1'b0;
      st_ra_pt    = pa_ff;
      st_ra_obj   = obj_ff;
      st_rb_pt    = pb_ff;
      st_rb_obj   = obj_ff;
      mac_start   = 1'b0;

      // register write while idle
      if (csr_valid && csr_ready) begin
         cfg_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            // load one coordinate
            if (start) begin
               st_we = !full;
               if (32'(cidx_ff) + 1 >= 32'(nobj)) begin
                  cidx_in = '0;
                  if (full) begin
                     ovf_in = 1'b1;
                  end else begin
                     loaded_in = loaded_ff + 1'b1;
                  end
                  if (last_point) begin
                     k_in        = nobj;
                     stk_idx     = OW'(nobj - 1'b1);
                     stk_we_cnt  = 1'b1;
                     stk_we_dist = 1'b1;
                     stk_we_vol  = 1'b1;
                     stk_cnt_wd  = full ? loaded_ff : loaded_ff + 1'b1;
                     state_in    = S_TEST;
                  end
               end else begin
                  cidx_in = cidx_ff + 1'b1;
               end
            end
         end
         S_TEST: begin
            // level loop test, return to parent when empty
            if (stk_cnt == '0) begin
               if (k_ff == nobj) begin
                  strobe_in   = 1'b1;
                  volout_in   = stk_vol;
                  drop_in     = ovf_ff;
                  ord_ctl.clr = 1'b1;
                  loaded_in   = '0;
                  cidx_in     = '0;
                  ovf_in      = 1'b0;
                  state_in    = S_IDLE;
               end else begin
                  inner_in = stk_vol;
                  k_in     = k_ff + 1'b1;
                  state_in = S_AFTER;
               end
            end else begin
               n_in     = stk_cnt;
               i_in     = '0;
               state_in = S_F_OUTER;
            end
         end
         S_F_OUTER: begin
            if (i_ff < n_ff) begin
               j_in     = i_inc;
               state_in = S_F_INNER;
            end else if (32'(k_ff) < BASE_LEVEL) begin
               ord_raddr_a = '0;
               state_in    = S_BASE_O;
            end else begin
               // descend one level with the survivors
               k_in        = k_ff - 1'b1;
               stk_idx     = OW'(k_ff - 2'd2);
               stk_we_cnt  = 1'b1;
               stk_we_dist = 1'b1;
               stk_we_vol  = 1'b1;
               stk_cnt_wd  = n_ff;
               state_in    = S_TEST;
            end
         end
         S_F_INNER: begin
            if (j_ff < n_ff) begin
               ord_raddr_a = i_ff[IW-1:0];
               ord_raddr_b = j_ff[IW-1:0];
               state_in    = S_F_ORD;
            end else begin
               i_in     = i_inc;
               state_in = S_F_OUTER;
            end
         end
         S_F_ORD: begin
            pa_in    = ord_rdata_a;
            pb_in    = ord_rdata_b;
            obj_in   = '0;
            age_in   = 1'b1;
            agt_in   = 1'b0;
            bge_in   = 1'b1;
            bgt_in   = 1'b0;
            state_in = S_F_RD;
         end
         S_F_RD: begin
            state_in = S_F_CMP;
         end
         S_F_CMP: begin
            // dominance flags, one objective a step
            if (st_rdata_a < st_rdata_b) begin
               age_in = 1'b0;
               bgt_in = 1'b1;
            end
            if (st_rdata_a > st_rdata_b) begin
               agt_in = 1'b1;
               bge_in = 1'b0;
            end
            obj_in = obj_ff + 1'b1;
            if (32'(obj_ff) + 2 < 32'(k_ff)) begin
               state_in = S_F_RD;
            end else begin
               state_in = S_F_DEC;
            end
         end
         S_F_DEC: begin
            priority if (age_ff && agt_ff) begin
               n_in        = n_dec;
               sa_in       = j_ff[IW-1:0];
               sb_in       = n_dec[IW-1:0];
               ord_raddr_a = j_ff[IW-1:0];
               ord_raddr_b = n_dec[IW-1:0];
               ret_in      = S_F_INNER;
               state_in    = S_SW_W1;
            end else if (bge_ff && bgt_ff) begin
               n_in        = n_dec;
               sa_in       = i_ff[IW-1:0];
               sb_in       = n_dec[IW-1:0];
               ord_raddr_a = i_ff[IW-1:0];
               ord_raddr_b = n_dec[IW-1:0];
               ret_in      = S_F_OUTER;
               state_in    = S_SW_W1;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_F_INNER;
            end
         end
         S_SW_W1: begin
            // swap two slots over two writes
            ord_ctl.we = 1'b1;
            ord_waddr  = sa_ff;
            ord_wdata  = ord_rdata_b;
            sva_in     = ord_rdata_a;
            state_in   = S_SW_W2;
         end
         S_SW_W2: begin
            ord_ctl.we = 1'b1;
            ord_waddr  = sb_ff;
            ord_wdata  = sva_ff;
            state_in   = ret_ff;
         end
         S_BASE_O: begin
            st_ra_pt  = ord_rdata_a;
            st_ra_obj = '0;
            state_in  = S_BASE_S;
         end
         S_BASE_S: begin
            inner_in = VOL_BITS'(st_rdata_a) << (VOL_BITS - COORD_BITS);
            state_in = S_AFTER;
         end
         S_AFTER: begin
            cnt_in      = stk_cnt;
            i_in        = '0;
            ord_raddr_a = '0;
            state_in    = S_MIN_O;
         end
         S_MIN_O: begin
            st_ra_pt  = ord_rdata_a;
            st_ra_obj = lv;
            state_in  = S_MIN_S;
         end
         S_MIN_S: begin
            // smallest value of this level's objective
            if (i_ff == '0 || st_rdata_a < low_ff) begin
               low_in = st_rdata_a;
            end
            i_in = i_inc;
            if (i_inc < cnt_ff) begin
               ord_raddr_a = i_inc[IW-1:0];
               state_in    = S_MIN_O;
            end else begin
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            mac_start = 1'b1;
            state_in  = S_MAC_W;
         end
         S_MAC_W: begin
            if (mac_done) begin
               stk_we_vol  = 1'b1;
               stk_vol_wd  = mac_sum;
               stk_we_dist = 1'b1;
               stk_dist_wd = low_ff;
               i_in        = '0;
               ord_raddr_a = '0;
               state_in    = S_RM_O;
            end
         end
         S_RM_O: begin
            st_ra_pt  = ord_rdata_a;
            st_ra_obj = lv;
            state_in  = S_RM_S;
         end
         S_RM_S: begin
            // drop points at or below the boundary
            if (st_rdata_a <= low_ff) begin
               cnt_in      = cnt_dec;
               sa_in       = i_ff[IW-1:0];
               sb_in       = cnt_dec[IW-1:0];
               ord_raddr_a = i_ff[IW-1:0];
               ord_raddr_b = cnt_dec[IW-1:0];
               ret_in      = S_RM_NEXT;
               state_in    = S_SW_W1;
            end else begin
               state_in = S_RM_NEXT;
            end
         end
         S_RM_NEXT: begin
            i_in = i_inc;
            if (i_inc < cnt_ff) begin
               ord_raddr_a = i_inc[IW-1:0];
               state_in    = S_RM_O;
            end else begin
               stk_we_cnt = 1'b1;
               stk_cnt_wd = cnt_ff;
               state_in   = S_TEST;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, front bookkeeping and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         cfg_ff    <= NOBJ_RESET;
         loaded_ff <= '0;
         cidx_ff   <= '0;
         ovf_ff    <= 1'b0;
         k_ff      <= KW'(2);
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         cfg_ff    <= cfg_in;
         loaded_ff <= loaded_in;
         cidx_ff   <= cidx_in;
         ovf_ff    <= ovf_in;
         k_ff      <= k_in;
         strobe_ff <= strobe_in;
         volout_ff <= volout_in;
         drop_ff   <= drop_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      cnt_ff   <= cnt_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      sa_ff    <= sa_in;
      sb_ff    <= sb_in;
      sva_ff   <= sva_in;
      obj_ff   <= obj_in;
      age_ff   <= age_in;
      agt_ff   <= agt_in;
      bge_ff   <= bge_in;
      bgt_ff   <= bgt_in;
      low_ff   <= low_in;
      inner_ff <= inner_in;
      if (stk_we_cnt) begin
         cnt_stk_ff[stk_idx] <= stk_cnt_wd;
      end
      if (stk_we_dist) begin
         dist_stk_ff[stk_idx] <= stk_dist_wd;
      end
      if (stk_we_vol) begin
         vol_stk_ff[stk_idx] <= stk_vol_wd;
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign csr_ready   = !busy;
   assign rsp_strobe  = strobe_ff;
   assign rsp_volume  = volout_ff;
   assign rsp_dropped = drop_ff;

endmodule

>>> design/hypervolume_indicator_top.sv
// Hypervolume of a front of points, sliced over objectives.
// Item channel: a coordinate word (req_coord_value, objective 0 first) is taken
// at a clock edge with start high and busy low. num_objectives words make a point;
// req_last_point high on the word that completes a point closes the front.
// Loading runs at one word per cycle into the coordinate memory while idle.
// After the closing word busy goes high and the sequencer computes the volume
// with one shared multiplier and the two-port order table. The time is data
// dependent: each pair compare in the dominance filter reads the two points
// one objective at a time, each dominated point costs a slot swap, and each
// slice takes a boundary pass over the points and then a slice product.
// The result (rsp_volume in Q0.48, rsp_points_dropped) is shown for one cycle
// with rsp_strobe; the receiver takes it then and cannot hold it off. The same
// cycle busy drops and the next front may load. Points beyond MAX_POINTS are not
// stored and raise rsp_points_dropped.
// csr_num_objectives is written through csr_valid/csr_ready while busy is low.
// Reset (synchronous) empties the front, sets two objectives and clears busy.
module hypervolume_indicator_top #(
   parameter int MAX_POINTS     = hvi_pkg::MAX_POINTS_DEF,
   parameter int MAX_OBJECTIVES = hvi_pkg::MAX_OBJECTIVES_DEF,
   parameter int COORD_BITS     = hvi_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [hvi_pkg::IN_COORD_BITS-1:0] req_coord_value,
   input  logic                              req_last_point,
   output logic                              rsp_strobe,
   output logic [hvi_pkg::VOL_BITS-1:0]      rsp_volume,
   output logic                              rsp_points_dropped,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hvi_pkg::CFG_BITS-1:0]      csr_num_objectives
);
   import hvi_pkg::*;

   localparam int IW = $clog2(MAX_POINTS);
   localparam int AW = IW + $clog2(MAX_OBJECTIVES);

   logic                  st_we;
   logic [AW-1:0]         st_waddr, st_raddr_a, st_raddr_b;
   logic [COORD_BITS-1:0] st_wdata, st_rdata_a, st_rdata_b;
   ord_ctl_type           ord_ctl;
   logic [IW-1:0]         ord_waddr, ord_wdata, ord_raddr_a, ord_raddr_b;
   logic [IW-1:0]         ord_rdata_a, ord_rdata_b;
   logic                  mac_start, mac_done;
   logic [VOL_BITS-1:0]   mac_acc, mac_vol, mac_sum;
   logic [COORD_BITS-1:0] mac_depth;
   logic [COORD_BITS-1:0] coord_word;

   // only the low coordinate bits count
   assign coord_word = COORD_BITS'(req_coord_value);

   // sequencer
   hvi_seq #(
      .MAX_POINTS     (MAX_POINTS),
      .MAX_OBJECTIVES (MAX_OBJECTIVES),
      .COORD_BITS     (COORD_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .coord_value (coord_word),
      .last_point  (req_last_point),
      .busy        (busy),
      .csr_valid   (csr_valid),
      .csr_data    (csr_num_objectives),
      .csr_ready   (csr_ready),
      .rsp_strobe  (rsp_strobe),
      .rsp_volume  (rsp_volume),
      .rsp_dropped (rsp_points_dropped),
      .st_we       (st_we),
      .st_waddr    (st_waddr),
      .st_wdata    (st_wdata),
      .st_raddr_a  (st_raddr_a),
      .st_raddr_b  (st_raddr_b),
      .st_rdata_a  (st_rdata_a),
      .st_rdata_b  (st_rdata_b),
      .ord_ctl     (ord_ctl),
      .ord_waddr   (ord_waddr),
      .ord_wdata   (ord_wdata),
      .ord_raddr_a (ord_raddr_a),
      .ord_raddr_b (ord_raddr_b),
      .ord_rdata_a (ord_rdata_a),
      .ord_rdata_b (ord_rdata_b),
      .mac_start   (mac_start),
      .mac_acc     (mac_acc),
      .mac_vol     (mac_vol),
      .mac_depth   (mac_depth),
      .mac_done    (mac_done),
      .mac_sum     (mac_sum)
   );

   // coordinate memory
   hvi_store #(
      .MAX_POINTS     (MAX_POINTS),
      .MAX_OBJECTIVES (MAX_OBJECTIVES),
      .COORD_BITS     (COORD_BITS)
   ) u_store (
      .clock     (clock),
      .wr_en     (st_we),
      .wr_addr   (st_waddr),
      .wr_data   (st_wdata),
      .rd_addr_a (st_raddr_a),
      .rd_addr_b (st_raddr_b),
      .rd_data_a (st_rdata_a),
      .rd_data_b (st_rdata_b)
   );

   // slot order table
   hvi_order #(
      .MAX_POINTS (MAX_POINTS)
   ) u_order (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ord_ctl),
      .wr_addr   (ord_waddr),
      .wr_data   (ord_wdata),
      .rd_addr_a (ord_raddr_a),
      .rd_addr_b (ord_raddr_b),
      .rd_data_a (ord_rdata_a),
      .rd_data_b (ord_rdata_b)
   );

   // shared multiply-accumulate
   hvi_mac #(
      .COORD_BITS (COORD_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .start (mac_start),
      .acc   (mac_acc),
      .vol   (mac_vol),
      .depth (mac_depth),
      .done  (mac_done),
      .sum   (mac_sum)
   );

endmodule

>>> design/hvi_checker.sv
module hvi_protocol_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic csr_ready
);

   // a result word lasts one cycle
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   // a result word ends a computation
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe without a finished computation");

   // computation starts only on an accepted word
   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted word");

   // register writes are held off during computation
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready)
      else $error("register port ready while busy");

endmodule

bind hypervolume_indicator_top hvi_protocol_checker u_hvi_checker (.*);
